### sv/alt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alt_pkg: shared types and constants of the array list table
// Capacity, field widths, operation codes and the structs that run
// between the top level and the row of list cells.
// ----------------------------------------------------------------------------
package alt_pkg;

  // list capacity and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // fixed field widths of the channels
  localparam int OP_W    = 2;
  localparam int VAL_W   = 32;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  typedef logic [OP_W-1:0]         op_t;
  typedef logic signed [VAL_W-1:0] val_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic             en;
    op_t              op;
    val_t             key;
    logic [CNT_W-1:0] cnt;
  } cell_ctl_t;

  // match chain handed from one cell to the next
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] pos;
  } cell_link_t;

  // one result beat
  typedef struct packed {
    logic               ok;
    logic               found;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    logic               is_full;
  } alt_res_t;

endpackage

### sv/alt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alt_if: channel interfaces of the array list table
// Input channel carries an operation and a value, the result channel
// carries the status of one operation; both use valid/ready.
// ----------------------------------------------------------------------------
interface alt_in_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              op;
  logic signed [31:0]      value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface alt_out_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic       found;
  logic [3:0] position;
  logic [4:0] count;
  logic       is_empty;
  logic       is_full;

  modport source (output valid, output ok, output found, output position,
                  output count, output is_empty, output is_full, input ready);
  modport sink   (input valid, input ok, input found, input position,
                  input count, input is_empty, input is_full, output ready);
endinterface

### sv/alt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alt_cell: one slot of the packed list
// Holds one entry, compares it against the key, extends the first-match
// chain and takes the right neighbor's entry on a delete at or past the
// first match.
// ----------------------------------------------------------------------------
module alt_cell (
  input  logic                       clk,
  input  alt_pkg::cell_ctl_t         ctl,
  input  logic [alt_pkg::IDX_W-1:0]  idx,
  input  alt_pkg::cell_link_t        link_in,
  output alt_pkg::cell_link_t        link_out,
  input  alt_pkg::val_t              nbr_data,
  output alt_pkg::val_t              data_out
);
  import alt_pkg::*;

  val_t data_r;
  val_t data_nxt;
  logic occ;
  logic full;
  logic match;

  // slot is live when it lies below the count
  assign occ   = CNT_W'(idx) < ctl.cnt;
  assign full  = ctl.cnt == CNT_W'(CAPACITY);
  assign match = occ && (data_r == ctl.key);

  // first-match chain
  always_comb begin
    link_out.hit = link_in.hit | match;
    link_out.pos = (!link_in.hit && match) ? idx : link_in.pos;
  end

  // entry update
  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      OP_APPEND: begin
        if (!full && (CNT_W'(idx) == ctl.cnt)) data_nxt = ctl.key;
      end
      OP_DELETE: begin
        if (link_out.hit) data_nxt = nbr_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en) data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule

### sv/array_list_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_table: fixed-capacity packed list of signed 32-bit values
// Append, delete-first-match, search and clear over a row of list cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_beat carries op (append, delete, search, clear) and a value;
//   out_beat returns one result beat per input beat: ok, found, position,
//   count, is_empty and is_full as they stand after the operation.
//   Every cell compares its entry against the value in the same cycle and
//   a hit/index chain through the row marks the first match; on a delete
//   the cells at and past that match take their right neighbor's entry.
//   An operation finishes in the cycle it is accepted: the result beat is
//   valid on the next cycle, and one beat per cycle is sustained while the
//   receiver takes every beat. The first-match chain through all cells sets
//   the critical path. The result sits in an output register; a new beat
//   is taken while it is being read. When the receiver stalls the result
//   holds and in_ready drops until the result beat is taken.
//   Reset (rst_n low, synchronous) empties the list and drops out_valid;
//   the cell contents are not cleared, only the count.
// ----------------------------------------------------------------------------
module array_list_table (
  input  logic       clk,
  input  logic       rst_n,
  alt_in_if.sink     in_beat,
  alt_out_if.source  out_beat
);
  import alt_pkg::*;

  cell_ctl_t        ctl;
  cell_link_t       link [CAPACITY+1];
  val_t             data [CAPACITY];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             out_valid_r;
  alt_res_t         res_r;
  alt_res_t         res_nxt;
  logic             accept;
  logic             full;

  // handshake: new beat whenever the output register is free or drained
  assign in_beat.ready = !out_valid_r || out_beat.ready;
  assign accept        = in_beat.valid && in_beat.ready;
  assign full          = cnt_r == CNT_W'(CAPACITY);

  // broadcast to the cells
  always_comb begin
    ctl.en  = accept;
    ctl.op  = in_beat.op;
    ctl.key = in_beat.value;
    ctl.cnt = cnt_r;
  end

  assign link[0] = '0;

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    alt_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .idx      (IDX_W'(i)),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .nbr_data ((i == CAPACITY - 1) ? data[i] : data[(i + 1) % CAPACITY]),
      .data_out (data[i])
    );
  end

  // count update and result
  always_comb begin
    cnt_nxt          = cnt_r;
    res_nxt          = '0;
    case (in_beat.op)
      OP_APPEND: begin
        if (!full) begin
          cnt_nxt    = cnt_r + CNT_W'(1);
          res_nxt.ok = 1'b1;
        end
      end
      OP_DELETE: begin
        if (link[CAPACITY].hit) begin
          cnt_nxt          = cnt_r - CNT_W'(1);
          res_nxt.ok       = 1'b1;
          res_nxt.found    = 1'b1;
          res_nxt.position = POS_W'(link[CAPACITY].pos);
        end
      end
      OP_SEARCH: begin
        if (link[CAPACITY].hit) begin
          res_nxt.ok       = 1'b1;
          res_nxt.found    = 1'b1;
          res_nxt.position = POS_W'(link[CAPACITY].pos);
        end
      end
      default: begin
        cnt_nxt    = '0;
        res_nxt.ok = 1'b1;
      end
    endcase
    res_nxt.count    = COUNT_W'(cnt_nxt);
    res_nxt.is_empty = cnt_nxt == '0;
    res_nxt.is_full  = cnt_nxt == CNT_W'(CAPACITY);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) cnt_r <= cnt_nxt;
      if (accept) out_valid_r <= 1'b1;
      else if (out_beat.ready) out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) res_r <= res_nxt;
  end

  assign out_beat.valid    = out_valid_r;
  assign out_beat.ok       = res_r.ok;
  assign out_beat.found    = res_r.found;
  assign out_beat.position = res_r.position;
  assign out_beat.count    = res_r.count;
  assign out_beat.is_empty = res_r.is_empty;
  assign out_beat.is_full  = res_r.is_full;

endmodule

### sv/alt_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alt_chk: port checker of the array list table
// Watches the result channel for hold under stall, reset behavior and
// consistency of the status flags.
// ----------------------------------------------------------------------------
module alt_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       ok,
  input logic       found,
  input logic [4:0] position,
  input logic [4:0] count,
  input logic       is_empty,
  input logic       is_full
);
  import alt_pkg::*;

  // stalled result beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(count) && $stable(ok)
      && $stable(found) && $stable(position))
    else $error("result beat changed while stalled");

  // reset drops the result channel
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // empty and full flags follow the count
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (is_empty == (count == '0))
      && (is_full == (count == COUNT_W'(CAPACITY))))
    else $error("status flags disagree with count");

  // a match always means success, even when a delete empties the list
  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && found |-> ok)
    else $error("found without ok");

endmodule

bind array_list_table alt_chk u_alt_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_beat.valid),
  .out_ready (out_beat.ready),
  .ok        (out_beat.ok),
  .found     (out_beat.found),
  .position  ({1'b0, out_beat.position}),
  .count     (out_beat.count),
  .is_empty  (out_beat.is_empty),
  .is_full   (out_beat.is_full)
);

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the array list table
// Sends append, delete, search and clear beats while both channels idle at
// random outside the back-to-back phase. A shadow copy of the list predicts
// each status beat, and every returned beat is compared, in order, to it.
// ----------------------------------------------------------------------------
module tb;
  import alt_pkg::*;

  localparam int   QUIET_LIMIT  = 2000;
  localparam int   MAX_REPORTS  = 200;
  localparam int   RANDOM_ITEMS = 210;
  localparam int   CLEAR_PCT    = 3;
  localparam val_t VAL_MIN      = 32'sh8000_0000;
  localparam val_t VAL_MAX      = 32'sh7FFF_FFFF;

  logic clk = 1'b0;
  logic rst_n;

  alt_in_if  in_ch ();
  alt_out_if out_ch ();

  array_list_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_ch),
    .out_beat (out_ch)
  );

  // shadow copy of the list and status beats still owed by the block
  val_t        shadow_vals [CAPACITY];
  int          shadow_len = 0;
  alt_res_t    owed_status [$];

  int unsigned send_idle_pct = 14;
  int unsigned recv_idle_pct = 68;
  int          mismatches    = 0;
  int          reports       = 0;
  int          quiet_cycles  = 0;

  // clock
  always #2 clk = ~clk;

  // index of the first shadow entry equal to key, -1 when none
  function automatic int first_hit(val_t key);
    for (int i = 0; i < shadow_len; i++)
      if (shadow_vals[i] == key) return i;
    return -1;
  endfunction

  // apply one operation to the shadow list and return the status it yields
  function automatic alt_res_t apply_list_op(op_t op, val_t value);
    alt_res_t res;
    int       hit;
    res = '0;
    hit = first_hit(value);
    case (op)
      OP_APPEND: begin
        if (shadow_len < CAPACITY) begin
          shadow_vals[shadow_len] = value;
          shadow_len++;
          res.ok = 1'b1;
        end
      end
      OP_DELETE: begin
        if (hit >= 0) begin
          res.ok       = 1'b1;
          res.found    = 1'b1;
          res.position = POS_W'(hit);
          for (int j = hit; j < shadow_len - 1; j++)
            shadow_vals[j] = shadow_vals[j + 1];
          shadow_len--;
        end
      end
      OP_SEARCH: begin
        if (hit >= 0) begin
          res.ok       = 1'b1;
          res.found    = 1'b1;
          res.position = POS_W'(hit);
        end
      end
      default: begin
        shadow_len = 0;
        res.ok     = 1'b1;
      end
    endcase
    res.count    = COUNT_W'(shadow_len);
    res.is_empty = (shadow_len == 0);
    res.is_full  = (shadow_len == CAPACITY);
    return res;
  endfunction

  // values for appends: a small pool for duplicates, the extremes, any value
  function automatic val_t pick_value();
    int unsigned sel;
    sel = $urandom_range(7);
    if (sel < 4) return val_t'($urandom_range(8)) - 32'sd4;
    if (sel == 4) return VAL_MIN;
    if (sel == 5) return VAL_MAX;
    return val_t'($urandom());
  endfunction

  // keys for delete and search: mostly a value that is in the list
  function automatic val_t pick_key();
    if (shadow_len > 0 && $urandom_range(3) != 0)
      return shadow_vals[$urandom_range(shadow_len - 1)];
    return pick_value();
  endfunction

  // send one beat, idling before it, and record its predicted status
  task automatic send_beat(op_t op, val_t value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.op    = op;
    in_ch.value = value;
    do @(posedge clk); while (!in_ch.ready);
    owed_status.push_back(apply_list_op(op, value));
  endtask

  // hold the sender off until every owed status beat has come back
  task automatic wait_all_status();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (owed_status.size() != 0) @(posedge clk);
  endtask

  // receiver stalls
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (reports < MAX_REPORTS) begin
        reports++;
        $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      end
    end
  endtask

  // compare each status beat with the oldest prediction
  always @(posedge clk) begin
    alt_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (owed_status.size() == 0) begin
        mismatches++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t ns: status beat expected none, got count %0d",
                   $time, out_ch.count);
        end
      end else begin
        want = owed_status.pop_front();
        check_field("ok",       want.ok,       out_ch.ok);
        check_field("found",    want.found,    out_ch.found);
        check_field("position", want.position, out_ch.position);
        check_field("count",    want.count,    out_ch.count);
        check_field("is_empty", want.is_empty, out_ch.is_empty);
        check_field("is_full",  want.is_full,  out_ch.is_full);
      end
    end
  end

  // watchdog on cycles with no beat moving on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // delete and search with nothing stored
  task automatic test_empty_list();
    send_beat(OP_SEARCH, 32'sd5);
    send_beat(OP_DELETE, 32'sd0);
  endtask

  // extreme values, duplicates, a miss and deleting the only entry
  task automatic test_extremes_and_duplicates();
    send_beat(OP_APPEND, VAL_MIN);
    send_beat(OP_APPEND, VAL_MAX);
    send_beat(OP_APPEND, VAL_MIN);
    send_beat(OP_SEARCH, VAL_MAX);
    send_beat(OP_SEARCH, 32'sd0);
    // only the first of the two equal entries goes
    send_beat(OP_DELETE, VAL_MIN);
    send_beat(OP_DELETE, VAL_MIN);
    send_beat(OP_DELETE, VAL_MAX);
  endtask

  // fill the list, get refused, hit the last slot, shift a full row, clear
  task automatic test_fill_to_capacity();
    for (int i = 0; i < CAPACITY; i++)
      send_beat(OP_APPEND, val_t'({8{4'(i)}}));
    send_beat(OP_APPEND, VAL_MAX);
    send_beat(OP_SEARCH, val_t'({8{4'(CAPACITY - 1)}}));
    send_beat(OP_DELETE, 32'sd0);
    send_beat(OP_CLEAR, val_t'($urandom()));
  endtask

  // random mix in bursts that lean toward filling or toward draining
  task automatic test_random_mix(int n_items);
    int unsigned append_pct;
    int          left_in_burst;
    int unsigned roll;
    op_t         op;
    val_t        value;
    append_pct    = 50;
    left_in_burst = 0;
    for (int i = 0; i < n_items; i++) begin
      if (left_in_burst == 0) begin
        append_pct    = $urandom_range(85, 15);
        left_in_burst = $urandom_range(40, 8);
      end
      left_in_burst--;
      roll = $urandom_range(99);
      if (roll < CLEAR_PCT) begin
        op = OP_CLEAR;
      end else if (roll < CLEAR_PCT + append_pct) begin
        op = OP_APPEND;
      end else if (roll[0]) begin
        op = OP_DELETE;
      end else begin
        op = OP_SEARCH;
      end
      if (op == OP_DELETE || op == OP_SEARCH) begin
        value = pick_key();
      end else begin
        value = pick_value();
      end
      send_beat(op, value);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.op     = OP_APPEND;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // slow receiver
    test_empty_list();
    test_extremes_and_duplicates();
    test_fill_to_capacity();
    test_random_mix(RANDOM_ITEMS);
    wait_all_status();

    // slow sender
    send_idle_pct = 68;
    recv_idle_pct = 14;
    test_random_mix(RANDOM_ITEMS);
    wait_all_status();

    // back to back
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(RANDOM_ITEMS);
    wait_all_status();

    repeat (8) @(posedge clk);
    if (mismatches == 0 && owed_status.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### array_list_table.f
sv/alt_pkg.sv
sv/alt_if.sv
sv/alt_cell.sv
sv/array_list_table.sv
sv/alt_chk.sv
tb/tb.sv
